/* hw/rtl/rc_command_to_motor_ramp_macros.svh */
// Assertion macros for the RC command to motor ramp block.
// Defining NO_ASSERTIONS removes every check.
`ifndef RC_COMMAND_TO_MOTOR_RAMP_MACROS_SVH
`define RC_COMMAND_TO_MOTOR_RAMP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define RCMR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcmr assertion failed");
// Next-cycle implication.
`define RCMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcmr assertion failed");
`else
`define RCMR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RCMR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/rcmr_pkg.sv */
// Types, constants and helper functions for the RC command to motor ramp block.
// No dependencies.
package rcmr_pkg;

   localparam logic [1:0] MODE_STOP  = 2'd0;
   localparam logic [1:0] MODE_FLY   = 2'd1;
   localparam logic [1:0] MODE_CLIMB = 2'd2;

   localparam int MODE_OFFSET  = 4000;
   localparam logic [15:0] MODE_STOP_LO = 16'(7800 + MODE_OFFSET);
   localparam logic [15:0] MODE_STOP_HI = 16'(8200 + MODE_OFFSET);

   localparam logic [15:0] SPEED_CENTRE_LO = 16'd11936;
   localparam logic [15:0] SPEED_CENTRE_HI = 16'd12064;
   localparam logic [15:0] SPEED_FWD_MAX   = 16'd15264;
   localparam logic [15:0] SPEED_REV_MIN   = 16'd8736;
   localparam logic [15:0] SPEED_OUTER_LO  = 16'd8000;
   localparam logic [15:0] SPEED_OUTER_HI  = 16'd16000;
   localparam logic [6:0]  DUTY_MAX        = 7'd100;

   localparam logic [16:0] CTRL_CENTRE = 17'd12000;
   localparam logic [15:0] CTRL_BIAS   = 16'd75;
   // floor(x / 75) = (x * ceil(2^24 / 75)) >> 24 for any 16-bit x
   localparam int          CTRL_SHIFT  = 24;
   localparam logic [17:0] CTRL_RECIP  = 18'((2**CTRL_SHIFT + 74) / 75);

   localparam int          TICK_BASE   = 20;
   localparam logic [9:0]  PERIOD_FAST = 10'(TICK_BASE);
   localparam logic [6:0]  LEVEL_ON    = 7'd3;

   typedef struct packed {
      logic [15:0] control_channel;
      logic [15:0] speed_channel;
      logic [15:0] mode_channel;
   } req_data_type;

   typedef struct packed {
      logic [5:0]  pad;
      logic [6:0]  crawl_duty;
      logic        crawl_enable;
      logic [6:0]  flap_duty;
      logic        flap_enable;
      logic [15:0] ctrl_pulse;
      logic [1:0]  mode;
   } rsp_data_type;

   typedef struct packed {
      logic       fast;
      logic [5:0] step;
      logic [4:0] reload;
   } ramp_cfg_type;

   typedef struct packed {
      logic [6:0] level;
      logic [4:0] count;
   } ramp_state_type;

   // 20/p - 1 for periods below 20
   function automatic logic [4:0] slow_reload(input logic [4:0] p);
      logic [4:0] r;
      case (p) inside
         5'd1:         r = 5'd19;
         5'd2:         r = 5'd9;
         5'd3:         r = 5'd5;
         5'd4:         r = 5'd4;
         5'd5:         r = 5'd3;
         5'd6:         r = 5'd2;
         [5'd7:5'd10]: r = 5'd1;
         default:      r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic ramp_cfg_type period_to_cfg(input logic [9:0] period);
      logic [9:0]   p;
      logic [17:0]  prod;
      ramp_cfg_type c;
      p = (period == 10'd0) ? 10'd1 : period;
      // p/20 = (p>>2)/5, (x*205)>>10 exact for x < 1024
      prod     = 18'(p[9:2]) * 18'd205;
      c.fast   = (p >= PERIOD_FAST);
      c.step   = prod[15:10];
      c.reload = slow_reload(p[4:0]);
      return c;
   endfunction

   function automatic logic [6:0] speed_to_target(input logic [15:0] s);
      logic [15:0] d;
      logic [6:0]  t;
      d = '0;
      if (s > SPEED_CENTRE_LO && s <= SPEED_CENTRE_HI) begin
         t = 7'd0;
      end else if (s > SPEED_CENTRE_HI && s <= SPEED_FWD_MAX) begin
         d = s - SPEED_CENTRE_HI;
         t = {d[11:7], 2'b00};
      end else if (s > SPEED_REV_MIN && s <= SPEED_CENTRE_LO) begin
         d = SPEED_CENTRE_LO - s;
         t = {d[11:7], 2'b00};
      end else if (s > SPEED_OUTER_LO && s < SPEED_OUTER_HI) begin
         t = DUTY_MAX;
      end else begin
         t = 7'd0;
      end
      return t;
   endfunction

   function automatic ramp_state_type ramp(input ramp_state_type cur,
                                          input logic [6:0] target,
                                          input ramp_cfg_type cfg);
      ramp_state_type nx;
      logic [6:0]     gap;
      gap = target - cur.level;
      nx  = cur;
      if (cur.level >= target) begin
         nx.level = target;
         nx.count = 5'd0;
      end else if (cfg.fast) begin
         nx.level = (gap > 7'(cfg.step)) ? cur.level + 7'(cfg.step) : target;
         nx.count = 5'd0;
      end else if (cur.count == 5'd0) begin
         nx.level = cur.level + 7'd1;
         nx.count = cfg.reload;
      end else begin
         nx.count = cur.count - 5'd1;
      end
      return nx;
   endfunction

endpackage

/* hw/rtl/rc_command_to_motor_ramp.sv */
// Top level of the RC command to motor ramp block: input register, single
// pass of command/ramp logic, result register. Uses rcmr_pkg and the macros header.
`include "rc_command_to_motor_ramp_macros.svh"

// Takes one beat per clock unless the result register is stalled; beats pass the
// input register, then the result register. The single combinational pass holds
// the mode and speed compares, the ramp add/compare per motor and one 16x18
// constant multiply that divides the control offset from centre by 75.
// The tick period is decoded into ramp step and divider settings as it is written.
module rc_command_to_motor_ramp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // mode_channel, speed_channel, control_channel
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // mode, ctrl_pulse, flap_enable, flap_duty, crawl_enable, crawl_duty, zero pad
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_data
);

   logic                    s1_valid_ff, s1_valid_in;
   rcmr_pkg::req_data_type  s1_data_ff;
   logic                    s1_func_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rcmr_pkg::rsp_data_type  rsp_data_ff, rsp_data_in;
   rcmr_pkg::ramp_cfg_type  cfg_ff;

   logic [1:0]              mode_ff, mode_in;
   logic [15:0]             control_ff, control_in;
   logic [6:0]              flap_target_ff, flap_target_in;
   logic [6:0]              crawl_target_ff, crawl_target_in;
   rcmr_pkg::ramp_state_type flap_ff, flap_in;
   rcmr_pkg::ramp_state_type crawl_ff, crawl_in;

   logic                    advance;
   logic                    req_accept;
   logic [6:0]              motion;
   logic [16:0]             ctrl_diff;
   logic                    ctrl_neg;
   logic [15:0]             ctrl_mag;
   logic [33:0]             ctrl_prod;
   logic [15:0]             ctrl_quot;
   logic [15:0]             ctrl_q;
   logic [1:0]              cmd_mode;

   assign csr_ready  = 1'b1;
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // command decode
   always_comb begin
      if (s1_data_ff.mode_channel > rcmr_pkg::MODE_STOP_LO &&
          s1_data_ff.mode_channel < rcmr_pkg::MODE_STOP_HI) begin
         cmd_mode = rcmr_pkg::MODE_STOP;
      end else if (s1_data_ff.mode_channel < rcmr_pkg::MODE_STOP_LO) begin
         cmd_mode = rcmr_pkg::MODE_FLY;
      end else begin
         cmd_mode = rcmr_pkg::MODE_CLIMB;
      end
   end

   assign motion    = rcmr_pkg::speed_to_target(s1_data_ff.speed_channel);
   assign ctrl_diff = {1'b0, s1_data_ff.control_channel} - rcmr_pkg::CTRL_CENTRE;
   assign ctrl_neg  = ctrl_diff[16];
   assign ctrl_mag  = ctrl_neg ? 16'(-ctrl_diff) : ctrl_diff[15:0];
   assign ctrl_prod = 34'(ctrl_mag) * 34'(rcmr_pkg::CTRL_RECIP);
   assign ctrl_quot = 16'(ctrl_prod[33:rcmr_pkg::CTRL_SHIFT]);
   assign ctrl_q    = ctrl_neg ? rcmr_pkg::CTRL_BIAS - ctrl_quot
                               : rcmr_pkg::CTRL_BIAS + ctrl_quot;

   always_comb begin
      mode_in         = mode_ff;
      control_in      = control_ff;
      flap_target_in  = flap_target_ff;
      crawl_target_in = crawl_target_ff;
      flap_in         = flap_ff;
      crawl_in        = crawl_ff;
      if (!s1_func_ff) begin
         mode_in    = cmd_mode;
         control_in = {ctrl_q[14:0], 1'b0};
         unique case (cmd_mode)
            rcmr_pkg::MODE_FLY:   flap_target_in = motion;
            rcmr_pkg::MODE_CLIMB: crawl_target_in = motion;
            default: begin
               flap_target_in  = 7'd0;
               crawl_target_in = 7'd0;
            end
         endcase
      end else begin
         flap_in  = rcmr_pkg::ramp(flap_ff, flap_target_ff, cfg_ff);
         crawl_in = rcmr_pkg::ramp(crawl_ff, crawl_target_ff, cfg_ff);
      end
   end

   always_comb begin
      rsp_data_in               = '0;
      rsp_data_in.mode          = mode_in;
      rsp_data_in.ctrl_pulse    = control_in;
      rsp_data_in.flap_enable   = flap_in.level > rcmr_pkg::LEVEL_ON;
      rsp_data_in.crawl_enable  = crawl_in.level > rcmr_pkg::LEVEL_ON;
      if (rsp_data_in.flap_enable) begin
         rsp_data_in.flap_duty = (flap_in.level > rcmr_pkg::DUTY_MAX) ?
                                 rcmr_pkg::DUTY_MAX : flap_in.level;
      end
      if (rsp_data_in.crawl_enable) begin
         rsp_data_in.crawl_duty = (crawl_in.level > rcmr_pkg::DUTY_MAX) ?
                                  rcmr_pkg::DUTY_MAX : crawl_in.level;
      end
   end

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         cfg_ff          <= rcmr_pkg::period_to_cfg(rcmr_pkg::PERIOD_FAST);
         mode_ff         <= rcmr_pkg::MODE_STOP;
         control_ff      <= '0;
         flap_target_ff  <= '0;
         crawl_target_ff <= '0;
         flap_ff         <= '0;
         crawl_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cfg_ff <= rcmr_pkg::period_to_cfg(csr_data);
         end
         if (advance) begin
            mode_ff         <= mode_in;
            control_ff      <= control_in;
            flap_target_ff  <= flap_target_in;
            crawl_target_ff <= crawl_target_in;
            flap_ff         <= flap_in;
            crawl_ff        <= crawl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= rcmr_pkg::req_data_type'(req_tdata);
         s1_func_ff <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `RCMR_ASSERT_IMPLY(a_stop_clears, clock, reset, mode_ff == rcmr_pkg::MODE_STOP,
      flap_target_ff == 7'd0 && crawl_target_ff == 7'd0)
   `RCMR_ASSERT_IMPLY(a_level_range, clock, reset, 1'b1,
      flap_ff.level <= rcmr_pkg::DUTY_MAX && crawl_ff.level <= rcmr_pkg::DUTY_MAX)
   `RCMR_ASSERT_IMPLY(a_no_overrun, clock, reset,
      s1_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready)
   `RCMR_ASSERT_NEXT(a_result_follows, clock, reset, advance, rsp_valid_ff)

endmodule
